FILE: sv/owbps_pkg.sv
`timescale 1ns / 1ps

package owbps_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned SHIFT_W = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned INDEX_W = 3;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]         FRAME_CMD  = 8'h72;
  localparam logic [COUNT_W-1:0] FRAME_BITS = 5'd16;

  localparam logic [TICK_W-1:0]  LONG_TICKS_RST      = 16'd200;
  localparam logic [TICK_W-1:0]  SHORT_TICKS_RST     = 16'd100;
  localparam logic [TICK_W-1:0]  MARKER_TICKS_RST    = 16'd50;
  localparam logic [TICK_W-1:0]  RST_LOW_TICKS_RST   = 16'd1000;
  localparam logic [TICK_W-1:0]  RST_PULSE_TICKS_RST = 16'd200;
  localparam logic [TICK_W-1:0]  RST_GAP_TICKS_RST   = 16'd400;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST       = 8'd1;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST       = 8'd31;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_RESET  = 2'd1,
    REQ_SWITCH = 2'd2,
    REQ_LEVEL  = 2'd3
  } req_e;

  typedef enum logic [INDEX_W-1:0] {
    REG_LONG      = 3'd0,
    REG_SHORT     = 3'd1,
    REG_MARKER    = 3'd2,
    REG_RST_LOW   = 3'd3,
    REG_RST_PULSE = 3'd4,
    REG_RST_GAP   = 3'd5,
    REG_MIN_LEVEL = 3'd6,
    REG_MAX_LEVEL = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_PULSE = 3'd2,
    PH_RST_GAP   = 3'd3,
    PH_MARK      = 3'd4,
    PH_BIT_LO    = 3'd5,
    PH_BIT_HI    = 3'd6,
    PH_END_LOW   = 3'd7
  } phase_e;

  typedef struct packed {
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] marker_ticks;
    logic [TICK_W-1:0] rst_low_ticks;
    logic [TICK_W-1:0] rst_pulse_ticks;
    logic [TICK_W-1:0] rst_gap_ticks;
  } timing_t;

  typedef struct packed {
    req_e              op;
    logic              on_level;
    logic              level_ok;
    logic [CODE_W-1:0] code;
  } cmd_t;

endpackage

FILE: sv/owbps_front.sv
`timescale 1ns / 1ps

module owbps_front (
  input  logic [1:0]                    req_type_i,
  input  logic [owbps_pkg::LEVEL_W-1:0] req_value_i,
  input  logic [owbps_pkg::LEVEL_W-1:0] min_level_i,
  input  logic [owbps_pkg::LEVEL_W-1:0] max_level_i,
  output owbps_pkg::cmd_t               cmd_o
);
  import owbps_pkg::*;

  // Classify the request; range check against the limits at acceptance time.
  always_comb begin
    cmd_o.op       = req_e'(req_type_i);
    cmd_o.on_level = (req_value_i != '0);
    cmd_o.level_ok = (req_value_i != '0) && (req_value_i >= min_level_i) &&
                     (req_value_i <= max_level_i);
    cmd_o.code     = req_value_i[CODE_W-1:0];
  end

endmodule

FILE: sv/owbps_queue.sv
`timescale 1ns / 1ps

module owbps_queue #(
  parameter int unsigned DEPTH = owbps_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  owbps_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output owbps_pkg::cmd_t head_o
);
  import owbps_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o       = (count_q == FULL_CNT);
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

endmodule

FILE: sv/owbps_back.sv
`timescale 1ns / 1ps

module owbps_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  owbps_pkg::timing_t            timing_i,
  input  logic                          head_valid_i,
  input  owbps_pkg::cmd_t               head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          wire_level_o,
  output logic                          busy_res_o,
  output logic                          rejected_o
);
  import owbps_pkg::*;

  phase_e               phase_q, phase_d;
  logic [TICK_W-1:0]    timer_q, timer_d;
  logic [SHIFT_W-1:0]   shift_q, shift_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 wire_q, wire_d;
  logic                 out_valid_q;
  logic                 busy_q, rej_q;
  logic                 busy_d, rej_d;
  logic                 busy;

  assign busy  = (phase_q != PH_IDLE);
  // Take the head command whenever the output slot is free or draining.
  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  // Next state of the sequencer for the head command.
  always_comb begin
    logic [COUNT_W-1:0] count_dec;
    count_dec = (count_q != '0) ? count_q - 1'b1 : '0;
    phase_d   = phase_q;
    timer_d   = timer_q;
    shift_d   = shift_q;
    count_d   = count_q;
    wire_d    = wire_q;
    case (head_i.op)
      REQ_TICK: begin
        if (busy) begin
          if (timer_q > 16'd1) begin
            timer_d = timer_q - 1'b1;
          end else begin
            case (phase_q)
              PH_RST_LOW: begin
                phase_d = PH_RST_PULSE;
                wire_d  = 1'b1;
                timer_d = timing_i.rst_pulse_ticks;
              end
              PH_RST_PULSE: begin
                phase_d = PH_RST_GAP;
                wire_d  = 1'b0;
                timer_d = timing_i.rst_gap_ticks;
              end
              PH_RST_GAP: begin
                phase_d = PH_IDLE;
                wire_d  = 1'b1;
                timer_d = '0;
              end
              PH_MARK: begin
                phase_d = PH_BIT_LO;
                wire_d  = 1'b0;
                timer_d = shift_q[SHIFT_W-1] ? timing_i.short_ticks
                                             : timing_i.long_ticks;
              end
              PH_BIT_LO: begin
                phase_d = PH_BIT_HI;
                wire_d  = 1'b1;
                timer_d = shift_q[SHIFT_W-1] ? timing_i.long_ticks
                                             : timing_i.short_ticks;
              end
              PH_BIT_HI: begin
                shift_d = {shift_q[SHIFT_W-2:0], 1'b0};
                count_d = count_dec;
                wire_d  = 1'b0;
                if (count_dec[2:0] == 3'd0) begin
                  phase_d = PH_END_LOW;
                  timer_d = timing_i.marker_ticks;
                end else begin
                  phase_d = PH_BIT_LO;
                  timer_d = shift_q[SHIFT_W-2] ? timing_i.short_ticks
                                               : timing_i.long_ticks;
                end
              end
              PH_END_LOW: begin
                wire_d = 1'b1;
                if (count_q == '0) begin
                  phase_d = PH_IDLE;
                  timer_d = '0;
                end else begin
                  phase_d = PH_MARK;
                  timer_d = timing_i.marker_ticks;
                end
              end
              default: begin
                phase_d = PH_IDLE;
                timer_d = '0;
              end
            endcase
          end
        end
      end
      REQ_RESET: begin
        if (!busy) begin
          phase_d = PH_RST_LOW;
          wire_d  = 1'b0;
          timer_d = timing_i.rst_low_ticks;
        end
      end
      REQ_SWITCH: begin
        if (!busy) begin
          wire_d = head_i.on_level;
        end
      end
      REQ_LEVEL: begin
        if (!busy && head_i.level_ok) begin
          shift_d = {FRAME_CMD, {(SHIFT_W-8-CODE_W){1'b0}}, head_i.code};
          count_d = FRAME_BITS;
          phase_d = PH_MARK;
          wire_d  = 1'b1;
          timer_d = timing_i.marker_ticks;
        end
      end
      default: ;
    endcase
  end

  // Result fields for the head command.
  always_comb begin
    busy_d = (phase_d != PH_IDLE);
    rej_d  = (head_i.op != REQ_TICK) &&
             (busy || ((head_i.op == REQ_LEVEL) && !head_i.level_ok));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      shift_q <= '0;
      count_q <= '0;
      wire_q  <= 1'b0;
    end else if (pop_o) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      count_q <= count_d;
      wire_q  <= wire_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      busy_q <= busy_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign wire_level_o = wire_q;
  assign busy_res_o   = busy_q;
  assign rejected_o   = rej_q;

  a_tick_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (head_i.op == REQ_TICK)) |=> !rejected_o)
    else $error("tick result flagged as rejected");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FRAME_BITS)
    else $error("bit count above frame length");

  a_idle_no_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (count_q == '0))
    else $error("idle with frame bits pending");

  a_low_phases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_RST_LOW) || (phase_q == PH_RST_GAP) ||
     (phase_q == PH_BIT_LO) || (phase_q == PH_END_LOW)) |-> !wire_q)
    else $error("wire high in a low phase");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (busy_res_o == (phase_q != PH_IDLE)))
    else $error("busy flag disagrees with sequencer phase");

endmodule

FILE: sv/one_wire_backlight_pulse_sender_unit.sv
`timescale 1ns / 1ps

// One-wire backlight dimming sender.
// Input channel (in_valid_i / in_ready_o) carries one transaction per tick or
// command: req_type_i selects tick, reset sequence, on/off or intensity, and
// req_value_i holds the on/off value or the level. Each input transaction
// yields exactly one result transaction on the output channel
// (out_valid_o / out_ready_i): wire level after the item, busy flag and
// rejected flag. The config channel (cfg_valid_i / cfg_ready_o) writes the
// timing and level-limit registers; it is always ready. Write it only while
// no results are outstanding.
// Path: an accepted input is written into the queue, then popped into the
// output register once that register is free or draining.
// Throughput: one item per clock while out_ready_i stays high; the sequencer
// retires one queued command per cycle into the single output register.
// A two-entry queue sits between the classifier and the sequencer. When the
// receiver stalls, the output register holds, the queue fills, and in_ready_o
// drops once the queue is full; nothing is lost.
// Reset: registers return to defaults, sequencer goes idle, wire drives low.
module one_wire_backlight_pulse_sender_unit #(
  parameter int unsigned QUEUE_DEPTH = owbps_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [owbps_pkg::LEVEL_W-1:0] req_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          wire_level_o,
  output logic                          busy_res_o,
  output logic                          rejected_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [owbps_pkg::INDEX_W-1:0] cfg_index_i,
  input  logic [owbps_pkg::TICK_W-1:0]  cfg_data_i
);
  import owbps_pkg::*;

  timing_t            timing_q;
  logic [LEVEL_W-1:0] min_level_q;
  logic [LEVEL_W-1:0] max_level_q;

  cmd_t cmd;
  cmd_t head;
  logic queue_full;
  logic head_valid;
  logic pop;
  logic push;

  // Config registers; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.long_ticks      <= LONG_TICKS_RST;
      timing_q.short_ticks     <= SHORT_TICKS_RST;
      timing_q.marker_ticks    <= MARKER_TICKS_RST;
      timing_q.rst_low_ticks   <= RST_LOW_TICKS_RST;
      timing_q.rst_pulse_ticks <= RST_PULSE_TICKS_RST;
      timing_q.rst_gap_ticks   <= RST_GAP_TICKS_RST;
      min_level_q              <= MIN_LEVEL_RST;
      max_level_q              <= MAX_LEVEL_RST;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_LONG:      timing_q.long_ticks      <= cfg_data_i;
        REG_SHORT:     timing_q.short_ticks     <= cfg_data_i;
        REG_MARKER:    timing_q.marker_ticks    <= cfg_data_i;
        REG_RST_LOW:   timing_q.rst_low_ticks   <= cfg_data_i;
        REG_RST_PULSE: timing_q.rst_pulse_ticks <= cfg_data_i;
        REG_RST_GAP:   timing_q.rst_gap_ticks   <= cfg_data_i;
        REG_MIN_LEVEL: min_level_q <= cfg_data_i[LEVEL_W-1:0];
        REG_MAX_LEVEL: max_level_q <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: classify the request and range-check intensity.
  owbps_front u_front (
    .req_type_i  (req_type_i),
    .req_value_i (req_value_i),
    .min_level_i (min_level_q),
    .max_level_i (max_level_q),
    .cmd_o       (cmd)
  );

  // Accept while the queue has room, independent of the output side.
  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && !queue_full;

  owbps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back: phase sequencer and output register.
  owbps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timing_i     (timing_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .wire_level_o (wire_level_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

endmodule
